>>> rtl/core/tmg_pkg.sv
// shared types, constants and field layout of the touch-to-mouse gesture unit
`default_nettype none

package tmg_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int TIME_BITS   = 48;
    localparam int COUNT_BITS  = 4;
    localparam int ID_BITS     = 32;
    localparam int RADIUS_BITS = 12;
    localparam int WINDOW_BITS = 32;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE_RADIUS   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_TAP_WINDOW = 2'd1;
    localparam logic [RADIUS_BITS-1:0]    RADIUS_RESET = 12'd16;
    localparam logic [WINDOW_BITS-1:0]    WINDOW_RESET = 32'd250000000;

    // request kinds on s_tuser
    localparam logic REQ_UPDATE  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // input tdata layout, lowest field first
    localparam int OFS_COUNT     = TIME_BITS;
    localparam int OFS_ID        = OFS_COUNT + COUNT_BITS;
    localparam int OFS_X         = OFS_ID + ID_BITS;
    localparam int OFS_Y         = OFS_X + COORD_BITS;
    localparam int IN_FIELD_BITS = OFS_Y + COORD_BITS;
    localparam int S_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

    // output tdata layout: four flags, then move_x, move_y
    localparam int OUT_FIELD_BITS = 4 + 2 * COORD_BITS;
    localparam int M_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // distance compare widths
    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int LIM_BITS  = 2 * RADIUS_BITS;
    localparam int CMP_BITS  = (DIST_BITS > LIM_BITS) ? DIST_BITS : LIM_BITS;

    // item classes decided by the front end
    localparam int CLS_BITS = 2;
    localparam logic [CLS_BITS-1:0] CLS_EMPTY   = 2'd0;
    localparam logic [CLS_BITS-1:0] CLS_UPDATE  = 2'd1;
    localparam logic [CLS_BITS-1:0] CLS_RELEASE = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CLS_BITS-1:0]   cls;
        logic [TIME_BITS-1:0]  now_ns;
        logic [COUNT_BITS-1:0] finger_count;
        logic [ID_BITS-1:0]    finger_id;
        logic [COORD_BITS-1:0] finger_x;
        logic [COORD_BITS-1:0] finger_y;
    } item_t;

    typedef struct packed {
        logic                  press_left;
        logic                  press_right;
        logic                  release_buttons;
        logic                  move_valid;
        logic [COORD_BITS-1:0] move_x;
        logic [COORD_BITS-1:0] move_y;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/tmg_front.sv
// front end: accepts touch requests, classifies them and hands them to the queue
`default_nettype none

module tmg_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tmg_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output tmg_pkg::item_t                       push_item
);
    import tmg_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    item_t stage_item_next;
    logic  in_fire;
    logic  [COUNT_BITS-1:0] in_count;

    // stage is free when empty or drained this cycle
    assign s_tready   = !stage_valid_reg || push_ready;
    assign in_fire    = s_tvalid && s_tready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;
    assign in_count   = s_tdata[OFS_COUNT +: COUNT_BITS];

    // unpack and classify the incoming transfer
    always_comb begin
        stage_item_next              = stage_item_reg;
        stage_valid_next             = stage_valid_reg;
        if (push_ready) begin
            stage_valid_next = 1'b0;
        end
        if (in_fire) begin
            stage_valid_next             = 1'b1;
            stage_item_next.now_ns       = s_tdata[TIME_BITS-1:0];
            stage_item_next.finger_count = in_count;
            stage_item_next.finger_id    = s_tdata[OFS_ID +: ID_BITS];
            stage_item_next.finger_x     = s_tdata[OFS_X +: COORD_BITS];
            stage_item_next.finger_y     = s_tdata[OFS_Y +: COORD_BITS];
            if (s_tuser == REQ_RELEASE) begin
                stage_item_next.cls = CLS_RELEASE;
            end else if (in_count == '0) begin
                stage_item_next.cls = CLS_EMPTY;
            end else begin
                stage_item_next.cls = CLS_UPDATE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_item_reg <= stage_item_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/tmg_queue.sv
// short register queue between the front end and the gesture back end
`default_nettype none

module tmg_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire tmg_pkg::item_t in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output tmg_pkg::item_t out_item
);
    import tmg_pkg::*;

    item_t                     entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      push;
    logic                      pop;

    assign in_ready  = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            if (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tmg_back.sv
// back end: gesture state, deadzone and double-tap decisions, result register
`default_nettype none

module tmg_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [tmg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tmg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               pop_valid,
    output logic                                    pop_ready,
    input  wire tmg_pkg::item_t                     pop_item,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output tmg_pkg::result_t                        res_data
);
    import tmg_pkg::*;

    // configuration
    logic [LIM_BITS-1:0]    lim_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [RADIUS_BITS-1:0] cfg_radius;

    // gesture state
    logic                  anchor_valid_reg, anchor_valid_next;
    logic [ID_BITS-1:0]    anchor_id_reg, anchor_id_next;
    logic [COORD_BITS-1:0] anchor_x_reg, anchor_x_next;
    logic [COORD_BITS-1:0] anchor_y_reg, anchor_y_next;
    logic                  moved_flag_reg, moved_flag_next;
    logic [COUNT_BITS-1:0] prior_count_reg, prior_count_next;
    logic [TIME_BITS-1:0]  release_time_reg, release_time_next;

    // result register
    logic    res_valid_reg, res_valid_next;
    result_t res_data_reg, res_data_next;

    logic                    fire;
    logic                    same_finger;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] sq_x;
    logic [2*COORD_BITS-1:0] sq_y;
    logic [DIST_BITS-1:0]    dist_sq;
    logic                    beyond_deadzone;
    logic [TIME_BITS-1:0]    age;
    logic                    in_window;

    assign pop_ready = !res_valid_reg || res_ready;
    assign fire      = pop_valid && pop_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // register writes; the squared radius is kept ready for the compare
    assign cfg_radius = cfg_data[RADIUS_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg    <= LIM_BITS'(RADIUS_RESET) * LIM_BITS'(RADIUS_RESET);
            window_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEADZONE_RADIUS: begin
                    lim_reg <= LIM_BITS'(cfg_radius) * LIM_BITS'(cfg_radius);
                end
                REG_DOUBLE_TAP_WINDOW: begin
                    window_reg <= cfg_data[WINDOW_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // squared distance from the anchor and double-tap age
    assign same_finger = anchor_valid_reg && (anchor_id_reg == pop_item.finger_id);
    assign dx = (anchor_x_reg >= pop_item.finger_x) ? (anchor_x_reg - pop_item.finger_x)
                                                    : (pop_item.finger_x - anchor_x_reg);
    assign dy = (anchor_y_reg >= pop_item.finger_y) ? (anchor_y_reg - pop_item.finger_y)
                                                    : (pop_item.finger_y - anchor_y_reg);
    assign sq_x = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
    assign sq_y = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    assign dist_sq = DIST_BITS'(sq_x) + DIST_BITS'(sq_y);
    assign beyond_deadzone = (CMP_BITS'(dist_sq) > CMP_BITS'(lim_reg));
    assign age       = pop_item.now_ns - release_time_reg;
    assign in_window = (age <= TIME_BITS'(window_reg));

    // state transition and result for the popped item
    always_comb begin
        anchor_valid_next = anchor_valid_reg;
        anchor_id_next    = anchor_id_reg;
        anchor_x_next     = anchor_x_reg;
        anchor_y_next     = anchor_y_reg;
        moved_flag_next   = moved_flag_reg;
        prior_count_next  = prior_count_reg;
        release_time_next = release_time_reg;
        res_valid_next    = res_valid_reg;
        res_data_next     = res_data_reg;
        if (res_ready) begin
            res_valid_next = 1'b0;
        end
        if (fire) begin
            res_valid_next = 1'b1;
            res_data_next  = '0;
            case (pop_item.cls)
                CLS_UPDATE: begin
                    if (same_finger) begin
                        if (beyond_deadzone) begin
                            res_data_next.press_left = in_window;
                            res_data_next.move_valid = 1'b1;
                            res_data_next.move_x     = pop_item.finger_x;
                            res_data_next.move_y     = pop_item.finger_y;
                            anchor_x_next            = pop_item.finger_x;
                            anchor_y_next            = pop_item.finger_y;
                            moved_flag_next          = 1'b1;
                        end
                    end else begin
                        anchor_valid_next = 1'b1;
                        anchor_id_next    = pop_item.finger_id;
                        anchor_x_next     = pop_item.finger_x;
                        anchor_y_next     = pop_item.finger_y;
                    end
                    prior_count_next = pop_item.finger_count;
                end
                CLS_RELEASE: begin
                    if (prior_count_reg == COUNT_BITS'(0)) begin
                        res_data_next.release_buttons = 1'b1;
                        moved_flag_next               = 1'b0;
                    end else if (prior_count_reg == COUNT_BITS'(1)) begin
                        release_time_next        = pop_item.now_ns;
                        res_data_next.press_left = !moved_flag_reg;
                        prior_count_next         = '0;
                    end else if (prior_count_reg == COUNT_BITS'(2)) begin
                        res_data_next.press_right = !moved_flag_reg;
                        prior_count_next          = '0;
                    end
                    anchor_valid_next = 1'b0;
                end
                default: begin
                    // empty update: nothing changes, all-zero result
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_valid_reg <= 1'b0;
            anchor_id_reg    <= '0;
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            moved_flag_reg   <= 1'b0;
            prior_count_reg  <= '0;
            release_time_reg <= '0;
            res_valid_reg    <= 1'b0;
        end else begin
            anchor_valid_reg <= anchor_valid_next;
            anchor_id_reg    <= anchor_id_next;
            anchor_x_reg     <= anchor_x_next;
            anchor_y_reg     <= anchor_y_next;
            moved_flag_reg   <= moved_flag_next;
            prior_count_reg  <= prior_count_next;
            release_time_reg <= release_time_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/touch_to_mouse_gesture_fsm_unit.sv
// top level of the touch-to-mouse gesture unit
// Usage:
//   s_ channel carries one touch request per transfer: s_tuser is the request
//   kind (touch update or all-fingers release), s_tdata the time stamp,
//   finger count, first finger id and coordinates.
//   m_ channel returns exactly one mouse action per request, in order.
//   cfg_ channel writes the deadzone radius (index 0) or the double-tap
//   window (index 1); write only while no request is in flight.
// Timing:
//   an input transfer passes the front register, the queue and the result
//   register before it shows on m_tvalid; one request per cycle sustained
//   while m_tready stays high.
// Reset:
//   aresetn low clears the queue, the gesture state and the result valid flag,
//   and restores the register defaults (radius 16, window 250 ms).
// Stall:
//   while m_tready is low the result holds; five more requests are buffered
//   in the front register and queue before s_tready drops (six in flight).
`default_nettype none

module touch_to_mouse_gesture_fsm_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: now_ns, finger_count, finger_id, finger_x, finger_y, zero pad
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tmg_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // s_tuser: req_type
    input  wire logic                               s_tuser,
    // m_tdata: press_left, press_right, release_buttons, move_valid,
    //          move_x, move_y, zero pad
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tmg_pkg::M_TDATA_BITS-1:0]        m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tmg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tmg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tmg_pkg::*;

    logic    q_in_valid;
    logic    q_in_ready;
    item_t   q_in_item;
    logic    q_out_valid;
    logic    q_out_ready;
    item_t   q_out_item;
    result_t res_data;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tmg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_item  (q_in_item)
    );

    tmg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    tmg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (q_out_valid),
        .pop_ready (q_out_ready),
        .pop_item  (q_out_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_data)
    );

    // pack the result, lowest field first
    assign m_tdata = M_TDATA_BITS'({res_data.move_y, res_data.move_x, res_data.move_valid,
                                    res_data.release_buttons, res_data.press_right,
                                    res_data.press_left});

    // an accepted request always lands in the front register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_in_valid)
        else $error("accepted request not held by front end");

    // every item taken from the queue yields a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_out_valid && q_out_ready) |=> m_tvalid)
        else $error("popped item produced no result");

    // a result without a move carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[4 +: 2*COORD_BITS] == '0))
        else $error("move coordinates set without move");

    // no result straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
